// ===== hw/rtl/hvd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hvd_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TC_W      = 3;

  // register map: coefficients sit at their own power, term count after them
  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 3'd6;
  localparam logic [TC_W-1:0]      TC_RESET       = 3'd1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  // control handed to every coefficient cell
  typedef struct packed {
    logic load;   // copy the neighbor's coefficient into the work slot
    logic shift;  // take the neighbor's work slot
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/horner_value_and_derivative.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Evaluates p(x) and p'(x) by Horner's rule over up to MAX_TERMS signed Q16.16
// coefficients. An item is taken when start is high and busy is low; its result
// appears on valid_o for exactly one cycle, once its n terms are folded in, where
// n is the term count in use (term_count clamped to 1..MAX_TERMS). The result cannot
// be held off: capture it in the cycle valid_o is high. A new item may be started
// in the cycle its predecessor's result is shown, but not while busy is high.
// The block has a single shared pair of multiply-add units, which folds in
// one coefficient per cycle while the coefficient cells shift the next one into place.
// Write coefficients and term_count only while no item is in flight.
module horner_value_and_derivative #(
  parameter int unsigned MAX_TERMS = 6,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic signed [hvd_pkg::DATA_W-1:0]   point_i,
  input  wire logic                                cfg_we_i,
  input  wire logic        [hvd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic        [hvd_pkg::DATA_W-1:0]   cfg_data_i,
  output      logic                                valid_o,
  output      logic signed [hvd_pkg::DATA_W-1:0]   poly_value_o,
  output      logic signed [hvd_pkg::DATA_W-1:0]   poly_slope_o,
  output      logic                                overflow_o
);
  import hvd_pkg::*;

  localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  state_e state_q, state_d;

  logic [TC_W-1:0]          tc_q;
  logic [TC_W-1:0]          n_start;
  logic [TC_W-1:0]          n_q, n_d;
  logic [TC_W-1:0]          steps_q, steps_d;
  logic signed [DATA_W-1:0] x_q, x_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] slope_q, slope_d;
  logic                     ovf_q, ovf_d;
  logic                     accept;

  cell_ctrl_t               cell_ctrl;
  logic signed [DATA_W-1:0] coef   [MAX_TERMS];
  logic signed [DATA_W-1:0] work   [MAX_TERMS];

  logic signed [DATA_W-1:0] head_coef;
  logic signed [DATA_W-1:0] top_coef;
  logic signed [DATA_W-1:0] v_sum, s_sum;
  logic                     v_sat, s_sat;

  // coefficient cells: each keeps a coefficient register and a work slot and hands its work slot upward
  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
    logic signed [DATA_W-1:0] prev_coef;
    logic signed [DATA_W-1:0] prev_work;
    if (k == 0) begin : g_first
      assign prev_coef = '0;
      assign prev_work = '0;
    end else begin : g_rest
      assign prev_coef = coef[k-1];
      assign prev_work = work[k-1];
    end
    hvd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_we_i    (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(k))),
      .cfg_data_i  (cfg_data_i),
      .ctrl_i      (cell_ctrl),
      .prev_coef_i (prev_coef),
      .prev_work_i (prev_work),
      .coef_o      (coef[k]),
      .work_o      (work[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= TC_RESET;
    end else if (cfg_we_i && (cfg_idx_i == REG_TERM_COUNT)) begin
      tc_q <= cfg_data_i[TC_W-1:0];
    end
  end

  always_comb begin
    if (tc_q == '0) begin
      n_start = TC_W'(1);
    end else if (tc_q > TC_W'(MAX_TERMS)) begin
      n_start = TC_W'(MAX_TERMS);
    end else begin
      n_start = tc_q;
    end
  end

  assign accept    = start && !busy;
  assign top_coef  = coef[IDX_W'(n_start - TC_W'(1))];
  // after the load and j shifts the cell at n-1 holds the coefficient of power n-2-j
  assign head_coef = work[IDX_W'(n_q - TC_W'(1))];

  hvd_step #(.FRAC_BITS(FRAC_BITS)) u_step_slope (
    .mul_a_i  (slope_q),
    .x_i      (x_q),
    .addend_i (val_q),
    .sum_o    (s_sum),
    .sat_o    (s_sat)
  );

  hvd_step #(.FRAC_BITS(FRAC_BITS)) u_step_value (
    .mul_a_i  (val_q),
    .x_i      (x_q),
    .addend_i (head_coef),
    .sum_o    (v_sum),
    .sat_o    (v_sat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE, S_DONE: begin
        if (accept) begin
          state_d = (n_start == TC_W'(1)) ? S_DONE : S_RUN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RUN: begin
        if (steps_q == TC_W'(1)) begin
          state_d = S_DONE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and cell control
  always_comb begin
    busy            = (state_q == S_RUN);
    valid_o         = (state_q == S_DONE);
    cell_ctrl.load  = accept;
    cell_ctrl.shift = (state_q == S_RUN);
  end

  always_comb begin
    n_d     = n_q;
    steps_d = steps_q;
    x_d     = x_q;
    val_d   = val_q;
    slope_d = slope_q;
    ovf_d   = ovf_q;
    if (accept) begin
      n_d     = n_start;
      steps_d = n_start - TC_W'(1);
      x_d     = point_i;
      val_d   = top_coef;
      slope_d = '0;
      ovf_d   = 1'b0;
    end else if (state_q == S_RUN) begin
      steps_d = steps_q - TC_W'(1);
      val_d   = v_sum;
      slope_d = s_sum;
      ovf_d   = ovf_q || v_sat || s_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      steps_q <= '0;
      n_q     <= TC_W'(1);
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    val_q   <= val_d;
    slope_q <= slope_d;
    ovf_q   <= ovf_d;
  end

  assign poly_value_o = val_q;
  assign poly_slope_o = slope_q;
  assign overflow_o   = ovf_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hvd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hvd_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic signed [hvd_pkg::DATA_W-1:0] cfg_data_i,
  input  wire hvd_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic signed [hvd_pkg::DATA_W-1:0] prev_coef_i,
  input  wire logic signed [hvd_pkg::DATA_W-1:0] prev_work_i,
  output      logic signed [hvd_pkg::DATA_W-1:0] coef_o,
  output      logic signed [hvd_pkg::DATA_W-1:0] work_o
);
  import hvd_pkg::*;

  logic signed [DATA_W-1:0] coef_q;
  logic signed [DATA_W-1:0] work_q, work_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      coef_q <= cfg_data_i;
    end
  end

  always_comb begin
    work_d = work_q;
    if (ctrl_i.load) begin
      work_d = prev_coef_i;
    end else if (ctrl_i.shift) begin
      work_d = prev_work_i;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign coef_o = coef_q;
  assign work_o = work_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hvd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One Horner multiply-add: addend + ((mul_a * x) >>> FRAC_BITS), saturated to 32 bits.
module hvd_step #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic signed [hvd_pkg::DATA_W-1:0] mul_a_i,
  input  wire logic signed [hvd_pkg::DATA_W-1:0] x_i,
  input  wire logic signed [hvd_pkg::DATA_W-1:0] addend_i,
  output      logic signed [hvd_pkg::DATA_W-1:0] sum_o,
  output      logic                             sat_o
);
  import hvd_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SUM_W-1:0]  sum;

  always_comb begin
    prod    = PROD_W'(mul_a_i) * PROD_W'(x_i);
    prod_sh = prod >>> FRAC_BITS;
    sum     = SUM_W'(addend_i) + SUM_W'(prod_sh);
    // in range only if every bit above the sign of a 32-bit result agrees
    sat_o   = !((&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1]));
    if (sat_o) begin
      sum_o = sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      sum_o = sum[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire
